>>> rtl/core/ihss_pkg.sv
// shared constants, codes and types of the image header size sniffer
package ihss_pkg;

  localparam int HEADER_CAPTURE_DEF = 26;
  localparam int POSITION_BITS_DEF  = 27;

  localparam logic [31:0] MAX_PIXELS_RST  = 32'(50 * 1000 * 1000);
  localparam logic [26:0] MAX_ENCODED_RST = 27'(64 * 1024 * 1024);

  // register indexes on the configuration port
  typedef enum logic {
    REG_MAX_PIXELS  = 1'b0,
    REG_MAX_ENCODED = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_LARGE   = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TOO_MANY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_JPEG = 3'd1,
    FMT_PNG  = 3'd2,
    FMT_WEBP = 3'd3,
    FMT_BMP  = 3'd4
  } format_t;

  localparam logic [7:0]  JPEG_SOI   = 8'hd8;
  localparam logic [7:0]  JPEG_SOS   = 8'hda;
  localparam logic [7:0]  VP8L_SIG   = 8'h2f;
  localparam logic [7:0]  VP8_SYNC0  = 8'h9d;
  localparam logic [13:0] VP8_DIM_MASK = 14'h3fff;
  localparam logic [7:0]  PNG_SIG0   = 8'h89;
  localparam logic [31:0] PNG_IHDR_LEN = 32'd13;
  localparam logic [31:0] TAG_VP8X   = 32'h58385056;
  localparam logic [31:0] TAG_VP8L   = 32'h4c385056;
  localparam logic [31:0] TAG_VP8    = 32'h20385056;

  // parser summary handed from the front to the back with each image
  typedef struct packed {
    logic        jpeg_ok;
    logic [15:0] jpeg_w;
    logic [15:0] jpeg_h;
    logic        webp_ok;
    logic [32:0] webp_end;
    logic [24:0] webp_w;
    logic [24:0] webp_h;
  } finish_info_t;

  function automatic logic [31:0] cat4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    return {a, b, c, d};
  endfunction

endpackage

>>> rtl/core/ihss_if.sv
// stream interfaces of the sniffer: byte input and result output
interface ihss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihss_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  format;
  logic [30:0] out_width;
  logic [30:0] out_height;
  modport source (output valid, output status, output format, output out_width,
                  output out_height, input ready);
  modport sink (input valid, input status, input format, input out_width,
                input out_height, output ready);
endinterface

>>> rtl/core/ihss_front.sv
// front: byte counter, header capture, jpeg and webp stream parsers
module ihss_front #(
  parameter int HEADER_CAPTURE = ihss_pkg::HEADER_CAPTURE_DEF,
  parameter int POSITION_BITS  = ihss_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  input  logic                        q_full,
  output logic                        push,
  output logic [POSITION_BITS-1:0]    rec_len,
  output logic [POSITION_BITS-1:0]    rec_frame_end,
  output logic [8*HEADER_CAPTURE-1:0] rec_hdr,
  output ihss_pkg::finish_info_t      rec_info
);
  import ihss_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int HC = HEADER_CAPTURE;
  localparam int IW = $clog2(HC);

  typedef enum logic [7:0] {
    JP_SOI       = 8'b00000001,
    JP_EXPECT_FF = 8'b00000010,
    JP_MARKER    = 8'b00000100,
    JP_LEN_HI    = 8'b00001000,
    JP_LEN_LO    = 8'b00010000,
    JP_SKIP      = 8'b00100000,
    JP_SOF_BODY  = 8'b01000000,
    JP_DONE      = 8'b10000000
  } jp_state_t;

  typedef enum logic [3:0] {
    WP_HEADER   = 4'b0001,
    WP_PAY_EVEN = 4'b0010,
    WP_PAY_ODD  = 4'b0100,
    WP_PAD      = 4'b1000
  } wp_state_t;

  logic          accept;
  logic [PB-1:0] pos, pos_next;
  logic [7:0]    hdr [HC];

  jp_state_t     jp_state, jp_state_next;
  logic          jp_fail, jp_fail_next;
  logic [15:0]   jp_left, jp_left_next;
  logic [PB-1:0] jp_end, jp_end_next;
  logic [7:0]    jp_marker, jp_marker_next;
  logic [31:0]   jp_size, jp_size_next;

  wp_state_t     wp_state, wp_state_next;
  logic          wp_fail, wp_fail_next;
  logic [3:0]    wp_fill, wp_fill_next;
  logic [31:0]   wp_left, wp_left_next;
  logic [31:0]   wp_tag, wp_tag_next;
  logic [7:0]    wp_pay [10];
  logic [7:0]    wp_pay_next [10];
  logic [7:0]    pv [10];
  logic [32:0]   wp_end, wp_end_next;
  logic          wp_found, wp_found_next;
  logic [24:0]   wp_bw, wp_bw_next, wp_bh, wp_bh_next;
  logic [49:0]   wp_area, wp_area_next;

  logic          cand_hit;
  logic [24:0]   cand_w, cand_h;
  logic [49:0]   cand_area;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last_byte;

  assign pos_next = (pos == '1) ? pos : pos + PB'(1);

  always_ff @(posedge clk) begin
    if (accept && pos < PB'(HC)) begin
      hdr[pos[IW-1:0]] <= data_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < HC; i++) begin
      rec_hdr[8*i +: 8] = (pos == PB'(i)) ? data_byte : hdr[i];
    end
  end

  // jpeg marker walker
  always_comb begin
    logic [15:0]   seg;
    logic [PB:0]   end_sum;
    logic          standalone;
    logic          is_sof;
    jp_state_next  = jp_state;
    jp_fail_next   = jp_fail;
    jp_left_next   = jp_left;
    jp_end_next    = jp_end;
    jp_marker_next = jp_marker;
    jp_size_next   = jp_size;
    seg     = {jp_left[15:8], data_byte};
    end_sum = {1'b0, jp_end} + (PB+1)'(seg);
    standalone = (data_byte == 8'h00) || (data_byte == 8'h01) || (data_byte == 8'hd8) ||
                 (data_byte == 8'hd9) || (data_byte[7:3] == 5'b11010);
    is_sof = (jp_marker[7:4] == 4'hc) && (jp_marker[3:0] != 4'h4) &&
             (jp_marker[3:0] != 4'h8) && (jp_marker[3:0] != 4'hc);
    if (!jp_fail) begin
      unique case (jp_state)
        JP_SOI: begin
          if (pos == '0) begin
            if (data_byte != 8'hff) jp_fail_next = 1'b1;
          end else if (data_byte != JPEG_SOI) begin
            jp_fail_next = 1'b1;
          end else begin
            jp_state_next = JP_EXPECT_FF;
          end
        end
        JP_EXPECT_FF: begin
          if (data_byte != 8'hff) jp_fail_next = 1'b1;
          else jp_state_next = JP_MARKER;
        end
        JP_MARKER: begin
          if (data_byte == 8'hff) begin
            jp_state_next = JP_MARKER;
          end else if (standalone) begin
            jp_state_next = JP_EXPECT_FF;
          end else if (data_byte == JPEG_SOS) begin
            jp_fail_next = 1'b1;
          end else begin
            jp_marker_next = data_byte;
            jp_state_next  = JP_LEN_HI;
          end
        end
        JP_LEN_HI: begin
          jp_left_next  = {data_byte, 8'h00};
          jp_end_next   = pos;
          jp_state_next = JP_LEN_LO;
        end
        JP_LEN_LO: begin
          if (seg < 16'd2) begin
            jp_fail_next = 1'b1;
          end else if (is_sof) begin
            if (seg < 16'd7) begin
              jp_fail_next = 1'b1;
            end else begin
              jp_end_next   = end_sum[PB] ? '1 : end_sum[PB-1:0];
              jp_size_next  = '0;
              jp_left_next  = 16'd5;
              jp_state_next = JP_SOF_BODY;
            end
          end else if (seg == 16'd2) begin
            jp_state_next = JP_EXPECT_FF;
          end else begin
            jp_left_next  = seg - 16'd2;
            jp_state_next = JP_SKIP;
          end
        end
        JP_SKIP: begin
          jp_left_next = jp_left - 16'd1;
          if (jp_left == 16'd1) jp_state_next = JP_EXPECT_FF;
        end
        JP_SOF_BODY: begin
          // precision byte first, then height and width big-endian
          unique case (jp_left)
            16'd4:   jp_size_next[15:8]  = data_byte;
            16'd3:   jp_size_next[7:0]   = data_byte;
            16'd2:   jp_size_next[31:24] = data_byte;
            16'd1:   jp_size_next[23:16] = data_byte;
            default: jp_size_next = jp_size;
          endcase
          jp_left_next = jp_left - 16'd1;
          if (jp_left == 16'd1) jp_state_next = JP_DONE;
        end
        JP_DONE: jp_state_next = JP_DONE;
        default: jp_state_next = jp_state;
      endcase
    end
  end

  // view of the payload with this byte written at the fill index
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      pv[i] = (wp_fill == 4'(i)) ? data_byte : wp_pay[i];
    end
  end

  // frame candidate once enough payload is in
  always_comb begin
    logic [3:0] fill_new;
    fill_new = wp_fill + 4'd1;
    cand_hit = 1'b0;
    cand_w   = '0;
    cand_h   = '0;
    if (fill_new == 4'd5 && wp_tag == TAG_VP8L && pv[0] == VP8L_SIG) begin
      cand_hit = 1'b1;
      cand_w   = 25'd1 + 25'(pv[1]) + 25'({pv[2][5:0], 8'h00});
      cand_h   = 25'd1 + 25'(pv[2][7:6]) + 25'({pv[3], 2'b00}) + 25'({pv[4][3:0], 10'h000});
    end else if (fill_new == 4'd10 && wp_tag == TAG_VP8X) begin
      cand_hit = 1'b1;
      cand_w   = 25'd1 + 25'({pv[6], pv[5], pv[4]});
      cand_h   = 25'd1 + 25'({pv[9], pv[8], pv[7]});
    end else if (fill_new == 4'd10 && wp_tag == TAG_VP8 && pv[3] == VP8_SYNC0 &&
                 pv[4] == 8'h01 && pv[5] == 8'h2a) begin
      cand_hit = 1'b1;
      cand_w   = 25'({pv[7], pv[6]} & {2'b00, VP8_DIM_MASK});
      cand_h   = 25'({pv[9], pv[8]} & {2'b00, VP8_DIM_MASK});
    end
  end

  assign cand_area = cand_w * cand_h;

  // webp riff chunk walker
  always_comb begin
    logic [33:0] pos34;
    logic [31:0] size;
    logic [33:0] room;
    wp_state_next = wp_state;
    wp_fail_next  = wp_fail;
    wp_fill_next  = wp_fill;
    wp_left_next  = wp_left;
    wp_tag_next   = wp_tag;
    wp_end_next   = wp_end;
    wp_found_next = wp_found;
    wp_bw_next    = wp_bw;
    wp_bh_next    = wp_bh;
    wp_area_next  = wp_area;
    for (int i = 0; i < 10; i++) wp_pay_next[i] = wp_pay[i];
    pos34 = 34'(pos);
    size  = {data_byte, wp_pay[6], wp_pay[5], wp_pay[4]};
    room  = {1'b0, wp_end} - (pos34 + 34'd1);
    if (pos == PB'(7)) begin
      wp_end_next = {1'b0, data_byte, hdr[6], hdr[5], hdr[4]} + 33'd8;
    end
    if (!wp_fail && pos34 >= 34'd12) begin
      unique case (wp_state)
        WP_HEADER: begin
          if (wp_fill == 4'd0 && pos34 + 34'd8 > {1'b0, wp_end}) begin
            wp_fail_next = 1'b1;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (wp_fill == 4'(i)) wp_pay_next[i] = data_byte;
            end
            wp_fill_next = wp_fill + 4'd1;
            if (wp_fill == 4'd7) begin
              wp_tag_next  = {pv[3], pv[2], pv[1], pv[0]};
              wp_fill_next = 4'd0;
              if (34'(size) + 34'(size[0]) > room) begin
                wp_fail_next = 1'b1;
              end else begin
                wp_left_next = size;
                if (size != 32'd0) wp_state_next = size[0] ? WP_PAY_ODD : WP_PAY_EVEN;
              end
            end
          end
        end
        WP_PAY_EVEN, WP_PAY_ODD: begin
          if (wp_fill < 4'd10) begin
            for (int i = 0; i < 10; i++) begin
              if (wp_fill == 4'(i)) wp_pay_next[i] = data_byte;
            end
            wp_fill_next = wp_fill + 4'd1;
            if (cand_hit && cand_w != '0 && cand_h != '0 &&
                (!wp_found || cand_area > wp_area)) begin
              wp_found_next = 1'b1;
              wp_bw_next    = cand_w;
              wp_bh_next    = cand_h;
              wp_area_next  = cand_area;
            end
          end
          wp_left_next = wp_left - 32'd1;
          if (wp_left == 32'd1) begin
            wp_fill_next  = 4'd0;
            wp_state_next = (wp_state == WP_PAY_ODD) ? WP_PAD : WP_HEADER;
          end
        end
        WP_PAD:  wp_state_next = WP_HEADER;
        default: wp_state_next = WP_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 10; i++) wp_pay[i] <= wp_pay_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos       <= '0;
      jp_state  <= JP_SOI;
      jp_fail   <= 1'b0;
      jp_left   <= '0;
      jp_end    <= '0;
      jp_marker <= '0;
      jp_size   <= '0;
      wp_state  <= WP_HEADER;
      wp_fail   <= 1'b0;
      wp_fill   <= '0;
      wp_left   <= '0;
      wp_tag    <= '0;
      wp_end    <= '0;
      wp_found  <= 1'b0;
      wp_bw     <= '0;
      wp_bh     <= '0;
      wp_area   <= '0;
    end else if (accept) begin
      pos       <= pos_next;
      jp_state  <= jp_state_next;
      jp_fail   <= jp_fail_next;
      jp_left   <= jp_left_next;
      jp_end    <= jp_end_next;
      jp_marker <= jp_marker_next;
      jp_size   <= jp_size_next;
      wp_state  <= wp_state_next;
      wp_fail   <= wp_fail_next;
      wp_fill   <= wp_fill_next;
      wp_left   <= wp_left_next;
      wp_tag    <= wp_tag_next;
      wp_end    <= wp_end_next;
      wp_found  <= wp_found_next;
      wp_bw     <= wp_bw_next;
      wp_bh     <= wp_bh_next;
      wp_area   <= wp_area_next;
    end
  end

  // summary of the image as it stands after the last byte
  assign rec_len       = pos_next;
  assign rec_frame_end = jp_end_next;
  always_comb begin
    rec_info.jpeg_ok  = !jp_fail_next && (jp_state_next == JP_DONE);
    rec_info.jpeg_w   = jp_size_next[31:16];
    rec_info.jpeg_h   = jp_size_next[15:0];
    rec_info.webp_ok  = !wp_fail_next && (wp_state_next == WP_HEADER) &&
                        (wp_fill_next == 4'd0) && wp_found_next;
    rec_info.webp_end = wp_end_next;
    rec_info.webp_w   = wp_bw_next;
    rec_info.webp_h   = wp_bh_next;
  end

endmodule

>>> rtl/core/ihss_queue.sv
// two-entry queue between the parsing front and the result back
module ihss_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         valid,
  input  logic         pop,
  output logic [W-1:0] dout
);
  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         do_pop;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign do_pop = pop && valid;
  assign dout   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      unique case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/ihss_back.sv
// back: format decision, pixel count product and result register
module ihss_back #(
  parameter int HEADER_CAPTURE = ihss_pkg::HEADER_CAPTURE_DEF,
  parameter int POSITION_BITS  = ihss_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [POSITION_BITS-1:0]    rec_len,
  input  logic [POSITION_BITS-1:0]    rec_frame_end,
  input  logic [8*HEADER_CAPTURE-1:0] rec_hdr,
  input  ihss_pkg::finish_info_t      rec_info,
  input  logic [31:0]                 max_pixels,
  input  logic [26:0]                 max_encoded_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [2:0]                  format,
  output logic [30:0]                 out_width,
  output logic [30:0]                 out_height
);
  import ihss_pkg::*;

  localparam int HC = HEADER_CAPTURE;

  logic [7:0]  h [HC];
  logic        en;
  logic        too_large;
  format_t     fmt;
  logic [30:0] dw, dh;

  logic        s1_valid, s1_large;
  format_t     s1_fmt;
  logic [30:0] s1_w, s1_h;
  logic        s2_valid, s2_large;
  format_t     s2_fmt;
  logic [30:0] s2_w, s2_h;
  logic [61:0] s2_prod;

  always_comb begin
    for (int i = 0; i < HC; i++) h[i] = rec_hdr[8*i +: 8];
  end

  // whole pipeline moves together, held while the result waits
  assign en    = !out_valid || out_ready;
  assign q_pop = q_valid && en;

  always_comb begin
    logic [33:0] len34;
    logic        jpeg_hit, png_hit, webp_hit, bmp_hit;
    logic [31:0] pw, ph, dib, rw, rh, ih;
    logic [15:0] cw, ch;
    logic        core_ok, info_ok;
    len34 = 34'(rec_len);
    too_large = (rec_len == '1) || (len34 > 34'(max_encoded_bytes));

    jpeg_hit = rec_info.jpeg_ok && (rec_len >= rec_frame_end) &&
               (rec_info.jpeg_w != 16'd0) && (rec_info.jpeg_h != 16'd0);

    pw = cat4(h[16], h[17], h[18], h[19]);
    ph = cat4(h[20], h[21], h[22], h[23]);
    png_hit = (len34 >= 34'd24) && (h[0] == PNG_SIG0) && (h[1] == 8'h50) &&
              (h[2] == 8'h4e) && (h[3] == 8'h47) && (h[4] == 8'h0d) && (h[5] == 8'h0a) &&
              (h[6] == 8'h1a) && (h[7] == 8'h0a) &&
              (cat4(h[8], h[9], h[10], h[11]) == PNG_IHDR_LEN) &&
              (cat4(h[12], h[13], h[14], h[15]) == 32'h49484452) &&
              (pw != 32'd0) && (ph != 32'd0) && !pw[31] && !ph[31];

    webp_hit = (len34 >= 34'd20) && (cat4(h[0], h[1], h[2], h[3]) == 32'h52494646) &&
               (cat4(h[8], h[9], h[10], h[11]) == 32'h57454250) &&
               ({1'b0, rec_info.webp_end} == len34) && rec_info.webp_ok;

    dib = cat4(h[17], h[16], h[15], h[14]);
    cw  = {h[19], h[18]};
    ch  = {h[21], h[20]};
    rw  = cat4(h[21], h[20], h[19], h[18]);
    rh  = cat4(h[25], h[24], h[23], h[22]);
    ih  = rh[31] ? (32'd0 - rh) : rh;
    core_ok = (cw != 16'd0) && (ch != 16'd0);
    // negative height means a top-down bitmap
    info_ok = (dib >= 32'd40) && (rw != 32'd0) && !rw[31] && (rh != 32'd0) &&
              (rh != 32'h80000000);
    bmp_hit = (len34 >= 34'd26) && (h[0] == 8'h42) && (h[1] == 8'h4d) &&
              ((dib == 32'd12) ? core_ok : info_ok);

    fmt = FMT_NONE;
    dw  = '0;
    dh  = '0;
    priority if (jpeg_hit) begin
      fmt = FMT_JPEG;
      dw  = 31'(rec_info.jpeg_w);
      dh  = 31'(rec_info.jpeg_h);
    end else if (png_hit) begin
      fmt = FMT_PNG;
      dw  = pw[30:0];
      dh  = ph[30:0];
    end else if (webp_hit) begin
      fmt = FMT_WEBP;
      dw  = 31'(rec_info.webp_w);
      dh  = 31'(rec_info.webp_h);
    end else if (bmp_hit) begin
      fmt = FMT_BMP;
      dw  = (dib == 32'd12) ? 31'(cw) : rw[30:0];
      dh  = (dib == 32'd12) ? 31'(ch) : ih[30:0];
    end else begin
      fmt = FMT_NONE;
    end
    if (too_large || fmt == FMT_NONE) begin
      dw = '0;
      dh = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_large <= too_large;
      s1_fmt   <= too_large ? FMT_NONE : fmt;
      s1_w     <= dw;
      s1_h     <= dh;
      s2_large <= s1_large;
      s2_fmt   <= s1_fmt;
      s2_w     <= s1_w;
      s2_h     <= s1_h;
      s2_prod  <= s1_w * s1_h;
      format     <= s2_fmt;
      out_width  <= s2_w;
      out_height <= s2_h;
      priority if (s2_large) status <= ST_TOO_LARGE;
      else if (s2_fmt == FMT_NONE) status <= ST_UNSUPPORTED;
      else if (s2_prod > 62'(max_pixels)) status <= ST_TOO_MANY;
      else status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

>>> rtl/core/image_header_size_sniffer_core.sv
// top level of the image header size sniffer
// Bytes of an encoded image enter on byte_in, one per transaction, with
// last_byte set on the final one. JPEG, PNG, WebP and BMP header parsers
// follow the stream side by side; one byte is taken every cycle while the
// queue is not full, the jpeg and webp parsers updating their state on
// each byte. After the last byte one result transaction on result_out gives
// status, format and dimensions; it passes through the queue, the decode
// stage, the pixel product stage and the output register.
// Results go through a two-entry queue and a three-stage pipeline, so the
// parsers keep taking bytes of the next image while a result waits; a
// stalled receiver holds the pipeline, and byte_in drops ready only when
// the queue is full. Reset clears the parsers, the queue and the pipeline
// and loads max_pixels 50000000 and max_encoded_bytes 67108864. The APB
// port holds max_pixels at 0x0 and max_encoded_bytes at 0x4. The user
// writes them only while no image is in flight; the block does not check.
module image_header_size_sniffer_core #(
  parameter int HEADER_CAPTURE = ihss_pkg::HEADER_CAPTURE_DEF,
  parameter int POSITION_BITS  = ihss_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ihss_byte_if.sink     byte_in,
  ihss_result_if.source result_out,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ihss_pkg::*;

  localparam int PB     = POSITION_BITS;
  localparam int HC     = HEADER_CAPTURE;
  localparam int INFO_W = $bits(finish_info_t);
  localparam int REC_W  = 2*PB + 8*HC + INFO_W;

  logic [31:0] max_pixels;
  logic [26:0] max_encoded_bytes;
  logic        wr_en;
  reg_index_t  reg_sel;

  logic                push, q_full, q_valid, q_pop;
  logic [PB-1:0]       f_len, f_end, b_len, b_end;
  logic [8*HC-1:0]     f_hdr, b_hdr;
  finish_info_t        f_info, b_info;
  logic [REC_W-1:0]    q_din, q_dout;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pixels        <= MAX_PIXELS_RST;
      max_encoded_bytes <= MAX_ENCODED_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_PIXELS:  max_pixels        <= pwdata;
        REG_MAX_ENCODED: max_encoded_bytes <= pwdata[26:0];
        default:         max_pixels        <= max_pixels;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_PIXELS:  prdata = max_pixels;
      REG_MAX_ENCODED: prdata = 32'(max_encoded_bytes);
      default:         prdata = '0;
    endcase
  end

  ihss_front #(
    .HEADER_CAPTURE (HC),
    .POSITION_BITS  (PB)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (byte_in.valid),
    .in_ready      (byte_in.ready),
    .data_byte     (byte_in.data_byte),
    .last_byte     (byte_in.last_byte),
    .q_full        (q_full),
    .push          (push),
    .rec_len       (f_len),
    .rec_frame_end (f_end),
    .rec_hdr       (f_hdr),
    .rec_info      (f_info)
  );

  assign q_din = {f_len, f_end, f_hdr, f_info};

  ihss_queue #(
    .W (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (q_dout)
  );

  assign b_len  = q_dout[REC_W-1 -: PB];
  assign b_end  = q_dout[REC_W-PB-1 -: PB];
  assign b_hdr  = q_dout[INFO_W +: 8*HC];
  assign b_info = finish_info_t'(q_dout[INFO_W-1:0]);

  ihss_back #(
    .HEADER_CAPTURE (HC),
    .POSITION_BITS  (PB)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .rec_len           (b_len),
    .rec_frame_end     (b_end),
    .rec_hdr           (b_hdr),
    .rec_info          (b_info),
    .max_pixels        (max_pixels),
    .max_encoded_bytes (max_encoded_bytes),
    .out_valid         (result_out.valid),
    .out_ready         (result_out.ready),
    .status            (result_out.status),
    .format            (result_out.format),
    .out_width         (result_out.out_width),
    .out_height        (result_out.out_height)
  );

endmodule

>>> tb/image_header_size_sniffer_core_chk.sv
// checker for the image header size sniffer: byte-level header prediction and result compare
module image_header_size_sniffer_core_chk
  import ihss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ihss_byte_if        byte_ch,
  ihss_result_if      res_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POS_SAT = (64'd1 << POSITION_BITS_DEF) - 1;
  localparam longint unsigned DIM_LIM = 64'h7fffffff;

  // jpeg walker phases
  localparam int JW_SOI = 0, JW_FF = 1, JW_MARKER = 2, JW_LEN_HI = 3, JW_LEN_LO = 4,
                 JW_SKIP = 5, JW_SOF = 6, JW_DONE = 7;
  // webp chunk walker phases
  localparam int WW_HEADER = 0, WW_EVEN = 1, WW_ODD = 2, WW_PAD = 3;

  typedef struct {
    status_t     st;
    format_t     fmt;
    logic [30:0] w;
    logic [30:0] h;
  } dims_result_t;

  dims_result_t dims_expected[$];

  logic [31:0]     max_pix;
  logic [26:0]     max_enc;
  longint unsigned byte_pos, jp_end, wp_decl, wp_best;
  logic [7:0]      hdr[HEADER_CAPTURE_DEF];
  logic [7:0]      wp_pay[10];
  int unsigned     jp_phase, jp_left, jp_size;
  int unsigned     wp_phase, wp_fill, wp_left, wp_tag;
  bit              wp_found, jp_fail, wp_fail;

  function automatic longint unsigned be32(int i);
    return {32'd0, hdr[i], hdr[i+1], hdr[i+2], hdr[i+3]};
  endfunction

  function automatic longint unsigned le32(int i);
    return {32'd0, hdr[i+3], hdr[i+2], hdr[i+1], hdr[i]};
  endfunction

  function automatic bit dims_ok(longint unsigned w, longint unsigned h);
    return w != 0 && h != 0 && w <= DIM_LIM && h <= DIM_LIM;
  endfunction

  function automatic void image_clear();
    byte_pos = 0;
    foreach (hdr[i]) hdr[i] = 8'd0;
    foreach (wp_pay[i]) wp_pay[i] = 8'd0;
    jp_phase = JW_SOI; jp_left = 0; jp_end = 0; jp_size = 0;
    wp_phase = WW_HEADER; wp_fill = 0; wp_left = 0; wp_tag = 0;
    wp_decl = 0; wp_best = 0; wp_found = 0; jp_fail = 0; wp_fail = 0;
  endfunction

  function automatic void frame_seen(longint unsigned w, longint unsigned h);
    longint unsigned bw, bh;
    if (w == 0 || h == 0) return;
    bw = (wp_best >> 24) + 1;
    bh = (wp_best & 64'hffffff) + 1;
    if (!wp_found || w * h > bw * bh) begin
      wp_best = (((w - 1) & 64'hffffff) << 24) | ((h - 1) & 64'hffffff);
      wp_found = 1;
    end
  endfunction

  function automatic void frame_check();
    longint unsigned w, h;
    if (wp_fill == 5 && wp_tag == TAG_VP8L && wp_pay[0] == VP8L_SIG) begin
      w = 1 + wp_pay[1] + (longint'(wp_pay[2] & 8'h3f) << 8);
      h = 1 + ((wp_pay[2] & 8'hc0) >> 6) + (longint'(wp_pay[3]) << 2)
          + (longint'(wp_pay[4] & 8'h0f) << 10);
      frame_seen(w, h);
    end else if (wp_fill == 10 && wp_tag == TAG_VP8X) begin
      frame_seen(1 + {wp_pay[6], wp_pay[5], wp_pay[4]}, 1 + {wp_pay[9], wp_pay[8], wp_pay[7]});
    end else if (wp_fill == 10 && wp_tag == TAG_VP8 && wp_pay[3] == VP8_SYNC0
                 && wp_pay[4] == 8'h01 && wp_pay[5] == 8'h2a) begin
      frame_seen({wp_pay[7], wp_pay[6]} & VP8_DIM_MASK, {wp_pay[9], wp_pay[8]} & VP8_DIM_MASK);
    end
  endfunction

  function automatic bit is_sof(int unsigned m);
    return m >= 8'hc0 && m <= 8'hcf && m != 8'hc4 && m != 8'hc8 && m != 8'hcc;
  endfunction

  function automatic void jpeg_walk(longint unsigned p, int unsigned b);
    int unsigned seg;
    if (jp_fail) return;
    case (jp_phase)
      JW_SOI: begin
        if (p == 0) begin
          if (b != 8'hff) jp_fail = 1;
        end else if (b != JPEG_SOI) jp_fail = 1;
        else jp_phase = JW_FF;
      end
      JW_FF: begin
        if (b != 8'hff) jp_fail = 1;
        else jp_phase = JW_MARKER;
      end
      JW_MARKER: begin
        if (b == 8'hff) ;
        else if (b <= 8'h01 || b == 8'hd8 || b == 8'hd9 || (b >= 8'hd0 && b <= 8'hd7))
          jp_phase = JW_FF;
        else if (b == JPEG_SOS) jp_fail = 1;
        else begin
          jp_size = b;
          jp_phase = JW_LEN_HI;
        end
      end
      JW_LEN_HI: begin
        jp_left = b << 8;
        jp_end = p;
        jp_phase = JW_LEN_LO;
      end
      JW_LEN_LO: begin
        seg = jp_left | b;
        if (seg < 2) jp_fail = 1;
        else if (is_sof(jp_size)) begin
          if (seg < 7) jp_fail = 1;
          else begin
            jp_end += seg;
            if (jp_end > POS_SAT) jp_end = POS_SAT;
            jp_size = 0;
            jp_left = 5;
            jp_phase = JW_SOF;
          end
        end else if (seg == 2) jp_phase = JW_FF;
        else begin
          jp_left = seg - 2;
          jp_phase = JW_SKIP;
        end
      end
      JW_SKIP: begin
        jp_left = (jp_left - 1) & 32'hffff;
        if (jp_left == 0) jp_phase = JW_FF;
      end
      JW_SOF: begin
        case (5 - jp_left)
          1: jp_size |= b << 8;
          2: jp_size |= b;
          3: jp_size |= b << 24;
          4: jp_size |= b << 16;
          default: ;
        endcase
        jp_left--;
        if (jp_left == 0) jp_phase = JW_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void webp_walk(longint unsigned p, logic [7:0] b);
    longint unsigned size;
    if (p == 7) wp_decl = le32(4) + 8;
    if (wp_fail || p < 12) return;
    case (wp_phase)
      WW_HEADER: begin
        if (wp_fill == 0 && p + 8 > wp_decl) begin
          wp_fail = 1;
          return;
        end
        wp_pay[wp_fill & 7] = b;
        wp_fill++;
        if (wp_fill < 8) return;
        wp_tag = {wp_pay[3], wp_pay[2], wp_pay[1], wp_pay[0]};
        size = {32'd0, wp_pay[7], wp_pay[6], wp_pay[5], wp_pay[4]};
        wp_fill = 0;
        if (size + (size & 1) > wp_decl - (p + 1)) begin
          wp_fail = 1;
          return;
        end
        wp_left = size;
        if (size != 0) wp_phase = size[0] ? WW_ODD : WW_EVEN;
      end
      WW_EVEN, WW_ODD: begin
        if (wp_fill < 10) begin
          wp_pay[wp_fill] = b;
          wp_fill++;
          frame_check();
        end
        wp_left--;
        if (wp_left == 0) begin
          wp_fill = 0;
          wp_phase = (wp_phase == WW_ODD) ? WW_PAD : WW_HEADER;
        end
      end
      default: wp_phase = WW_HEADER;
    endcase
  endfunction

  // works out the dimensions once the last byte of an image is in
  function automatic dims_result_t image_verdict(longint unsigned len);
    dims_result_t    r;
    longint unsigned w, h, rw, rh, dib;
    r.fmt = FMT_NONE;
    w = 0; h = 0;
    if (len >= POS_SAT || len > max_enc) begin
      r.st = ST_TOO_LARGE;
    end else begin
      if (!jp_fail && jp_phase == JW_DONE && len >= jp_end
          && dims_ok(jp_size >> 16, jp_size & 32'hffff)) begin
        r.fmt = FMT_JPEG; w = jp_size >> 16; h = jp_size & 32'hffff;
      end else if (len >= 24 && be32(0) == 64'h89504e47 && be32(4) == 64'h0d0a1a0a
                   && be32(8) == PNG_IHDR_LEN && be32(12) == 64'h49484452
                   && dims_ok(be32(16), be32(20))) begin
        r.fmt = FMT_PNG; w = be32(16); h = be32(20);
      end else if (len >= 20 && be32(0) == 64'h52494646 && be32(8) == 64'h57454250
                   && wp_decl == len && !wp_fail && wp_phase == WW_HEADER
                   && wp_fill == 0 && wp_found) begin
        r.fmt = FMT_WEBP; w = (wp_best >> 24) + 1; h = (wp_best & 64'hffffff) + 1;
      end else if (len >= 26 && hdr[0] == 8'h42 && hdr[1] == 8'h4d) begin
        dib = le32(14);
        if (dib == 12) begin
          rw = {hdr[19], hdr[18]};
          rh = {hdr[21], hdr[20]};
          if (dims_ok(rw, rh)) begin
            r.fmt = FMT_BMP; w = rw; h = rh;
          end
        end else if (dib >= 40) begin
          rw = le32(18);
          rh = le32(22);
          if (rw != 0 && rw <= DIM_LIM && rh != 0 && rh != 64'h80000000) begin
            // negative height means a top-down bitmap
            if (rh > DIM_LIM) rh = (64'h100000000 - rh) & 64'hffffffff;
            if (dims_ok(rw, rh)) begin
              r.fmt = FMT_BMP; w = rw; h = rh;
            end
          end
        end
      end
      if (r.fmt == FMT_NONE) r.st = ST_UNSUPPORTED;
      else r.st = (w * h > max_pix) ? ST_TOO_MANY : ST_OK;
    end
    if (r.fmt == FMT_NONE) begin
      w = 0; h = 0;
    end
    r.w = w[30:0];
    r.h = h[30:0];
    return r;
  endfunction

  function automatic void sniff_byte(logic [7:0] b, logic last);
    longint unsigned p;
    p = byte_pos;
    if (p < HEADER_CAPTURE_DEF) hdr[p] = b;
    jpeg_walk(p, b);
    webp_walk(p, b);
    byte_pos = (p < POS_SAT) ? p + 1 : POS_SAT;
    if (last) begin
      dims_expected.push_back(image_verdict(byte_pos));
      image_clear();
    end
  endfunction

  always @(posedge clk) begin
    dims_result_t e;
    if (rst) begin
      image_clear();
      dims_expected.delete();
      max_pix = MAX_PIXELS_RST;
      max_enc = MAX_ENCODED_RST;
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_ENCODED) max_enc = pwdata[26:0];
        else max_pix = pwdata;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (dims_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transaction with nothing expected: st=%0d fmt=%0d %0dx%0d",
                     $realtime, res_ch.status, res_ch.format, res_ch.out_width,
                     res_ch.out_height);
        end else begin
          e = dims_expected.pop_front();
          if (res_ch.status !== e.st || res_ch.format !== e.fmt
              || res_ch.out_width !== e.w || res_ch.out_height !== e.h) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected st=%0d fmt=%0d %0dx%0d, got st=%0d fmt=%0d %0dx%0d",
                       $realtime, e.st, e.fmt, e.w, e.h, res_ch.status, res_ch.format,
                       res_ch.out_width, res_ch.out_height);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) sniff_byte(byte_ch.data_byte, byte_ch.last_byte);
    end
    pending = dims_expected.size();
  end

endmodule

>>> tb/image_header_size_sniffer_core_tb.sv
// testbench top for the image header size sniffer: image stimulus, register writes, verdict
module image_header_size_sniffer_core_tb;
  import ihss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending, errors;
  int          cycles = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  bit          long_hold = 0;
  int          hold_cnt = 0;
  logic [7:0]  img[$];

  ihss_byte_if   byte_ch();
  ihss_result_if res_ch();

  image_header_size_sniffer_core i_dut (
    .clk(clk), .rst(rst), .byte_in(byte_ch), .result_out(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  image_header_size_sniffer_core_chk i_chk (
    .clk(clk), .rst(rst), .byte_ch(byte_ch), .res_ch(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .pending(pending), .errors(errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'd0;
    byte_ch.last_byte = 1'b0;
    res_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the result queue backs up
  always @(posedge clk) begin
    if (long_hold && hold_cnt < 400) begin
      res_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!long_hold) hold_cnt <= 0;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    byte_ch.valid <= 1'b0;
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic void put_rand(int n);
    repeat (n) img.push_back(8'($urandom));
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_be32(logic [31:0] v);
    img.push_back(v[31:24]); img.push_back(v[23:16]);
    img.push_back(v[15:8]); img.push_back(v[7:0]);
  endfunction

  function automatic logic [31:0] rnd_dim(int bits);
    int r;
    r = $urandom_range(15);
    if (r == 0) return 0;
    if (r < 3) return 32'($urandom) & ((64'd1 << bits) - 1);
    return $urandom_range(1, 300);
  endfunction

  function automatic void make_jpeg(logic [15:0] w, logic [15:0] h);
    int n;
    img = {8'hff, JPEG_SOI};
    repeat ($urandom_range(2)) begin
      n = $urandom_range(6);
      img.push_back(8'hff);
      if ($urandom_range(3) == 0) img.push_back(8'hff);
      img.push_back(8'he0 + 8'($urandom_range(15)));
      img.push_back(8'h00);
      img.push_back(8'(n + 2));
      put_rand(n);
      if ($urandom_range(3) == 0) begin
        img.push_back(8'hff);
        img.push_back(8'hd0);
      end
    end
    img.push_back(8'hff);
    img.push_back(8'hc0 + 8'($urandom_range(2)));
    img.push_back(8'h00); img.push_back(8'd17); img.push_back(8'd8);
    img.push_back(h[15:8]); img.push_back(h[7:0]);
    img.push_back(w[15:8]); img.push_back(w[7:0]);
    put_rand(10 + $urandom_range(4));
  endfunction

  function automatic void make_png(logic [31:0] w, logic [31:0] h);
    img = {PNG_SIG0, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};
    put_be32(PNG_IHDR_LEN);
    put_be32(32'h49484452);
    put_be32(w);
    put_be32(h);
    put_rand(5 + $urandom_range(6));
  endfunction

  function automatic void put_frame_chunk(int kind, logic [31:0] w, logic [31:0] h);
    int sz;
    case (kind)
      0: begin
        put_le(TAG_VP8X, 4); put_le(10, 4); put_rand(4);
        put_le(w - 1, 3); put_le(h - 1, 3);
      end
      1: begin
        sz = 5 + $urandom_range(3);
        put_le(TAG_VP8L, 4); put_le(sz, 4);
        img.push_back(VP8L_SIG);
        img.push_back(8'(w - 1));
        img.push_back({2'(h - 1), 6'((w - 1) >> 8)});
        img.push_back(8'((h - 1) >> 2));
        img.push_back({4'($urandom), 4'((h - 1) >> 10)});
        put_rand(sz - 5);
        if (sz[0]) img.push_back(8'd0);
      end
      default: begin
        sz = 10 + $urandom_range(2);
        put_le(TAG_VP8, 4); put_le(sz, 4); put_rand(3);
        img.push_back(VP8_SYNC0); img.push_back(8'h01); img.push_back(8'h2a);
        put_le(w, 2); put_le(h, 2);
        put_rand(sz - 10);
        if (sz[0]) img.push_back(8'd0);
      end
    endcase
  endfunction

  function automatic void make_webp();
    int sz;
    img = {8'h52, 8'h49, 8'h46, 8'h46, 8'h0, 8'h0, 8'h0, 8'h0, 8'h57, 8'h45, 8'h42, 8'h50};
    if ($urandom_range(2) == 0) begin
      sz = $urandom_range(5);
      put_le(32'h50434349, 4); put_le(sz, 4); put_rand(sz);
      if (sz[0]) img.push_back(8'd0);
    end
    repeat (1 + $urandom_range(1))
      put_frame_chunk($urandom_range(2), rnd_dim(14), rnd_dim(14));
    sz = img.size() - 8;
    for (int i = 0; i < 4; i++) img[4 + i] = 8'(sz >> (8 * i));
  endfunction

  function automatic void make_bmp(bit core, logic [31:0] w, logic [31:0] h);
    img = {8'h42, 8'h4d};
    put_rand(12);
    if (core) begin
      put_le(12, 4); put_le(w, 2); put_le(h, 2); put_rand(4 + $urandom_range(3));
    end else begin
      put_le($urandom_range(40, 124), 4); put_le(w, 4); put_le(h, 4);
      put_rand($urandom_range(6));
    end
  endfunction

  function automatic void make_random_image();
    int k, cut;
    k = $urandom_range(9);
    case (k)
      0, 1: make_jpeg(rnd_dim(16), rnd_dim(16));
      2, 3: make_png(rnd_dim(32), rnd_dim(32));
      4, 5: make_webp();
      6, 7: make_bmp($urandom_range(1), rnd_dim(32),
                     $urandom_range(1) ? -rnd_dim(31) : rnd_dim(32));
      8: begin
        img.delete();
        put_rand($urandom_range(1, 40));
      end
      default: begin
        make_webp();
        cut = $urandom_range(1, img.size());
        while (img.size() > cut) void'(img.pop_back());
      end
    endcase
    // corrupt a byte now and then to reach the reject paths
    if (k < 8 && $urandom_range(4) == 0) img[$urandom_range(img.size() - 1)] = 8'($urandom);
  endfunction

  initial begin
    logic [31:0] pix_set[5] = '{32'hffffffff, 32'd1, 32'd0, 32'd12345, 32'd50000000};
    logic [31:0] enc_set[5] = '{32'd67108864, 32'd40, 32'd0, 32'd60, 32'd1};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed images under reset register values
    make_jpeg(16'hffff, 16'hffff); send_image();
    make_jpeg(16'd1, 16'd1); send_image();
    img = {8'hff, JPEG_SOI, 8'hff, JPEG_SOS, 8'h00, 8'h08}; send_image();
    make_png(32'h7fffffff, 32'd1); send_image();
    make_png(32'h80000000, 32'd5); send_image();
    img.delete(); put_rand(1); send_image();
    img = {8'hff}; send_image();
    img.delete(); make_webp(); send_image();
    make_bmp(1, 32'd640, 32'd480); send_image();
    make_bmp(0, 32'd100, 32'hffffff38); send_image();
    make_bmp(0, 32'd100, 32'h80000000); send_image();
    make_bmp(0, 32'd7000, 32'd8000); send_image();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_MAX_PIXELS, pix_set[ph]);
      reg_write(REG_MAX_ENCODED, enc_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (1) begin
        make_random_image();
        send_image();
      end
      if (ph == 0) begin
        // back-pressure: short images while the receiver holds off
        send_idle_pct = 0;
        long_hold = 1;
        repeat (20) begin
          img.delete();
          put_rand($urandom_range(1, 3));
          send_image();
        end
        drain();
        long_hold = 0;
      end
      drain();
    end

    reg_write(REG_MAX_PIXELS, MAX_PIXELS_RST);
    reg_write(REG_MAX_ENCODED, 32'(MAX_ENCODED_RST));
    send_idle_pct = 20; recv_stall_pct = 20;
    repeat (2) begin
      make_random_image();
      send_image();
    end
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
